### rtl/lfu_pkg.sv
// Package for the LFU cache directory: sizes, derived widths and the
// line-select struct shared by the match, victim and top-level modules.
// No dependencies.
package lfu_pkg;

	localparam int LINES      = 16;
	localparam int PAGE_BITS  = 32;
	localparam int COUNT_BITS = 32;

	localparam int IDX_BITS   = (LINES > 1) ? $clog2(LINES) : 1;
	localparam int TREE_LEAVES = 1 << IDX_BITS;

	localparam int IN_BITS    = 32;
	localparam int LINE_BITS  = 4;
	localparam int OUT_BITS   = 8;

	typedef logic [PAGE_BITS-1:0]  page_t;
	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [IDX_BITS-1:0]   idx_t;

	typedef struct packed {
		logic found;
		idx_t idx;
	} line_sel_t;

endpackage

### rtl/lfu_match.sv
// Tag match across all lines of the LFU directory.
// Depends on lfu_pkg.
module lfu_match (
	input  lfu_pkg::page_t    page,
	input  lfu_pkg::page_t    tag [lfu_pkg::LINES],
	input  logic              valid [lfu_pkg::LINES],
	output lfu_pkg::line_sel_t sel
);
	import lfu_pkg::*;

	// A page sits in at most one valid line, so the OR of the hit indexes is exact
	always_comb begin
		sel = '0;
		for (int i = 0; i < LINES; i++) begin
			if (valid[i] && (tag[i] == page)) begin
				sel.found = 1'b1;
				sel.idx   = sel.idx | idx_t'(i);
			end
		end
	end

endmodule

### rtl/lfu_victim.sv
// Minimum-count tree choosing the replacement line; ties go to the lower index.
// Depends on lfu_pkg.
module lfu_victim (
	input  lfu_pkg::count_t    count [lfu_pkg::LINES],
	input  logic               valid [lfu_pkg::LINES],
	output lfu_pkg::line_sel_t sel
);
	import lfu_pkg::*;

	// heap layout: node 1 is the root, leaves start at TREE_LEAVES
	count_t node_cnt [2*TREE_LEAVES];
	idx_t   node_idx [2*TREE_LEAVES];

	always_comb begin
		node_cnt[0] = '1;
		node_idx[0] = '0;
		for (int i = 0; i < TREE_LEAVES; i++) begin
			if (i < LINES) begin
				node_cnt[TREE_LEAVES+i] = valid[i] ? count[i] : '0;
			end else begin
				node_cnt[TREE_LEAVES+i] = '1;
			end
			node_idx[TREE_LEAVES+i] = idx_t'(i);
		end
		// left child wins on equal, so padding on the right never displaces a line
		for (int n = TREE_LEAVES - 1; n >= 1; n--) begin
			if (node_cnt[2*n+1] < node_cnt[2*n]) begin
				node_cnt[n] = node_cnt[2*n+1];
				node_idx[n] = node_idx[2*n+1];
			end else begin
				node_cnt[n] = node_cnt[2*n];
				node_idx[n] = node_idx[2*n];
			end
		end
		sel.found = 1'b1;
		sel.idx   = node_idx[1];
	end

endmodule

### rtl/lfu_cache_replacement.sv
// Top level of the fully associative LFU cache directory: input register,
// line state, result register. Uses lfu_pkg, lfu_match and lfu_victim.
//
// Channel   Dir  Fields (tdata / tuser, from bit 0 up)
// s_*       in   tdata: page_id[31:0]
// m_*       out  tdata: line[3:0], zeros[7:4]; tuser: hit
//
// One request per cycle while results are taken. A request is held in the input
// register, where tag match, victim choice and the line update all resolve, and
// its result is then registered in the output register.
// Reset clears all valid bits and counts at once; tags are written on fill.
// A stalled result holds the input register; s_tready then drops until the
// result is taken.
module lfu_cache_replacement (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [lfu_pkg::IN_BITS-1:0]  s_tdata,   // page_id
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [lfu_pkg::OUT_BITS-1:0] m_tdata,   // line, zero fill
	output logic                         m_tuser    // hit
);
	import lfu_pkg::*;

	logic      valid_s1;
	page_t     page_s1;
	logic      advance;

	page_t     tag_q   [LINES];
	logic      valid_q [LINES];
	count_t    count_q [LINES];

	line_sel_t hit_sel;
	line_sel_t vic_sel;

	logic                 m_valid_q;
	logic                 hit_q;
	logic [LINE_BITS-1:0] line_q;

	assign advance  = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			page_s1 <= page_t'(s_tdata);
		end
	end

	lfu_match u_match (
		.page  (page_s1),
		.tag   (tag_q),
		.valid (valid_q),
		.sel   (hit_sel)
	);

	lfu_victim u_victim (
		.count (count_q),
		.valid (valid_q),
		.sel   (vic_sel)
	);

	// valid bits and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LINES; i++) begin
				valid_q[i] <= 1'b0;
				count_q[i] <= '0;
			end
		end else if (advance) begin
			if (hit_sel.found) begin
				// saturate at all ones
				if (count_q[hit_sel.idx] != '1) begin
					count_q[hit_sel.idx] <= count_q[hit_sel.idx] + count_t'(1);
				end
			end else begin
				valid_q[vic_sel.idx] <= 1'b1;
				count_q[vic_sel.idx] <= count_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && !hit_sel.found) begin
			tag_q[vic_sel.idx] <= page_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			hit_q  <= hit_sel.found;
			line_q <= hit_sel.found ? LINE_BITS'(hit_sel.idx) : LINE_BITS'(vic_sel.idx);
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = hit_q;
	assign m_tdata  = {{(OUT_BITS-LINE_BITS){1'b0}}, line_q};

endmodule

### rtl/lfu_checker.sv
// Port-level checker for the LFU cache directory, bound to the top level.
// Depends on lfu_pkg and lfu_cache_replacement.
module lfu_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic [lfu_pkg::IN_BITS-1:0]  s_tdata,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [lfu_pkg::OUT_BITS-1:0] m_tdata,
	input logic                         m_tuser
);
	import lfu_pkg::*;

	localparam int MISS_BITS = $clog2(LINES + 1);

	logic [1:0]           pend_q;
	logic [MISS_BITS-1:0] miss_q;
	logic                 in_acc;
	logic                 out_acc;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	// requests in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
		end
	end

	// misses delivered since reset, held once every line is filled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			miss_q <= '0;
		end else if (out_acc && !m_tuser && (miss_q < MISS_BITS'(LINES))) begin
			miss_q <= miss_q + MISS_BITS'(1);
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output back-pressure");

	a_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 2'd2)
		else $error("more than two requests in flight");

	a_out_needs_req: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pend_q != 2'd0)
		else $error("result without a request");

	a_fill_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && !m_tuser && (miss_q < MISS_BITS'(LINES))
			|-> m_tdata[LINE_BITS-1:0] == LINE_BITS'(miss_q))
		else $error("empty lines not filled in index order");

endmodule

bind lfu_cache_replacement lfu_checker u_lfu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

### test/tb_lfu_cache_replacement.sv
`timescale 1ns / 100ps
// Testbench for lfu_cache_replacement: drives page requests on the slave stream and
// checks each hit/line result against a behavioural LFU directory kept here.
// Depends on lfu_pkg and the lfu_cache_replacement RTL.
module tb_lfu_cache_replacement;
	import lfu_pkg::*;

	typedef struct packed {
		logic       hit;
		logic [3:0] line;
	} lookup_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [IN_BITS-1:0]  s_tdata = '0;   // page_id
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OUT_BITS-1:0] m_tdata;        // line[3:0], zeros[7:4]
	logic                m_tuser;        // hit

	logic [IN_BITS-1:0] pending_pages[$];
	lookup_t            expected_lookups[$];
	int unsigned        mismatches = 0;

	// directory as the block should hold it
	page_t  held_tag[LINES];
	logic   held_valid[LINES];
	count_t use_count[LINES];

	int unsigned send_gap, send_calm = 0;
	int unsigned recv_gap, recv_calm = 0;

	lfu_cache_replacement i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic log_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	// Hit: bump the line's count, holding it at all ones. Miss: fill the line
	// with the lowest count (empty lines count zero), lowest index on a tie.
	function automatic lookup_t lookup_page(input page_t page);
		lookup_t res;
		int      slot;
		count_t  lowest, c;
		slot = -1;
		for (int i = 0; i < LINES; i++)
			if (slot < 0 && held_valid[i] && held_tag[i] == page)
				slot = i;
		if (slot >= 0) begin
			res.hit = 1'b1;
			if (use_count[slot] != '1)
				use_count[slot] = use_count[slot] + 1'b1;
		end else begin
			res.hit = 1'b0;
			slot = 0;
			lowest = held_valid[0] ? use_count[0] : '0;
			for (int i = 1; i < LINES; i++) begin
				c = held_valid[i] ? use_count[i] : '0;
				if (c < lowest) begin
					lowest = c;
					slot = i;
				end
			end
			held_tag[slot] = page;
			held_valid[slot] = 1'b1;
			use_count[slot] = 1;
		end
		res.line = slot[3:0];
		return res;
	endfunction

	// A random idle gap before each word, with occasional runs of back-to-back words.
	function automatic int unsigned draw_wait(inout int unsigned calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm = $urandom_range(16, 64);
			return 0;
		end
		return $urandom_range(0, 7);
	endfunction

	always @(posedge clk or negedge arst_n) begin : drive_requests
		logic               next_valid;
		logic [IN_BITS-1:0] next_data;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			send_gap = 0;
			for (int i = 0; i < LINES; i++) begin
				held_tag[i] = '0;
				held_valid[i] = 1'b0;
				use_count[i] = '0;
			end
		end else begin
			next_valid = s_tvalid;
			next_data = s_tdata;
			if (s_tvalid && s_tready) begin
				expected_lookups.push_back(lookup_page(page_t'(s_tdata)));
				next_valid = 1'b0;
				send_gap = draw_wait(send_calm);
			end
			if (!next_valid) begin
				if (send_gap > 0)
					send_gap--;
				else if (pending_pages.size() > 0) begin
					next_valid = 1'b1;
					next_data = pending_pages.pop_front();
				end
			end
			s_tvalid <= next_valid;
			s_tdata <= next_data;
		end
	end

	always @(posedge clk or negedge arst_n) begin : check_results
		lookup_t want;
		logic    next_ready;
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_gap = 0;
		end else begin
			next_ready = m_tready;
			if (m_tvalid && m_tready) begin
				if (expected_lookups.size() == 0) begin
					log_mismatch($sformatf("result word (hit %b, tdata %h) with nothing pending",
						m_tuser, m_tdata));
				end else begin
					want = expected_lookups.pop_front();
					if (m_tuser !== want.hit)
						log_mismatch($sformatf("hit %b, expected %b", m_tuser, want.hit));
					if (m_tdata !== {4'b0000, want.line})
						log_mismatch($sformatf("tdata %h, expected line %0d", m_tdata,
							want.line));
				end
				recv_gap = draw_wait(recv_calm);
				next_ready = (recv_gap == 0);
			end else if (!m_tready) begin
				if (recv_gap > 0)
					recv_gap--;
				next_ready = (recv_gap == 0);
			end
			m_tready <= next_ready;
		end
	end

	initial begin : stimulus
		logic [IN_BITS-1:0] pool[$];
		int unsigned        pool_size, hot, pick;
		// page 0 is a real page: first a miss into line 0, then a hit
		pending_pages.push_back(32'h0000_0000);
		pending_pages.push_back(32'h0000_0000);
		pending_pages.push_back(32'hFFFF_FFFF);
		pending_pages.push_back(32'hAAAA_AAAA);
		pending_pages.push_back(32'h5555_5555);
		pending_pages.push_back(32'h8000_0000);
		pending_pages.push_back(32'h0000_0001);
		for (int k = 1; k <= 10; k++)
			pending_pages.push_back(32'h0101_0101 * k);
		// directory full: misses keep evicting line 1, the lowest-index count-1 line, then re-hit
		pending_pages.push_back(32'h1234_5678);
		pending_pages.push_back(32'hFFFF_FFFF);
		pending_pages.push_back(32'h1234_5678);
		pending_pages.push_back(32'h0000_0000);
		pending_pages.push_back(32'h0000_0001);

		// working sets below, near and above the directory size
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: pool_size = 5;
				1: pool_size = 14;
				2: pool_size = 17;
				default: pool_size = 40;
			endcase
			pool.delete();
			for (int k = 0; k < pool_size; k++)
				pool.push_back(($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 255)) :
					$urandom);
			hot = pool_size / 4 + 1;
			for (int n = 0; n < 333; n++) begin
				pick = $urandom_range(0, 9);
				if (pick == 0)
					pending_pages.push_back($urandom);
				else if (pick < 6)
					pending_pages.push_back(pool[$urandom_range(0, hot - 1)]);
				else
					pending_pages.push_back(pool[$urandom_range(0, pool_size - 1)]);
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// look mid-cycle, once the driver and monitor have settled
		while (pending_pages.size() > 0 || s_tvalid)
			@(negedge clk);
		while (expected_lookups.size() > 0)
			@(negedge clk);
		// catch any stray word after the last expected one
		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
